>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; included by name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ckss_pkg.sv
// shared types and constants of the key square store
// no dependencies; imported by the core, the wrap-sub unit, the checker and the bench
`default_nettype none

package ckss_pkg;

   // field widths
   localparam int OP_W       = 3;
   localparam int IDX_W      = 3;
   localparam int CODE_W     = 8;
   localparam int SIZE_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_W      = 24;
   localparam int RSP_W      = 16;

   // default largest side of the square
   localparam int MAX_SIDE_DEFAULT = 8;

   // register reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd5;
   localparam logic [CODE_W-1:0] NULL_RESET = 8'd0;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
   localparam logic [OP_W-1:0] OP_READ     = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
   localparam logic [OP_W-1:0] OP_SWAP_ROW = 3'd3;
   localparam logic [OP_W-1:0] OP_SWAP_COL = 3'd4;
   localparam logic [OP_W-1:0] OP_ROTATE   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NULL_CODE   = 1'd1;

endpackage

`default_nettype wire

>>> hw/rtl/cipher_key_square_store_core.sv
// key square store: square matrix of letter codes with write, read, find,
// row and column swaps and cyclic rotation. One item at a time: ready again as
// the result goes out. Synchronous reset; per-entry valid bits make entries never
// written read zero.
`default_nettype none

module cipher_key_square_store_core import ckss_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // op, row_index, col_index, other_index, letter_code
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_W-1:0]      req_tdata,
   // read_code, found, found_row, found_col
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int RC_W  = $clog2(MAX_SIDE);
   localparam int MAX_N = (MAX_SIDE < 15) ? MAX_SIDE : 15;
   localparam logic [AW-1:0]     SIDE_A = AW'(MAX_SIDE);
   localparam logic [SIZE_W-1:0] SIDE_N = SIZE_W'(MAX_N);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_READ, S_READ_WAIT, S_FIND, S_MOD, S_COPY, S_PERM, S_DONE
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [RC_W-1:0] r,
                                             input logic [RC_W-1:0] c);
      return AW'(r) * SIDE_A + AW'(c);
   endfunction

   // control registers
   state_type          state_ff, state_in;
   logic               walk_busy_ff, walk_busy_in;
   logic [RC_W-1:0]    r_ff, r_in, c_ff, c_in;
   logic [SIZE_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [AW-1:0]      pend_addr_ff;
   logic [RC_W-1:0]    pend_r_ff, pend_c_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [CODE_W-1:0]  null_ff;
   logic               main_valid_ff [DEPTH];
   logic               rd_valid_ff;

   // item and result payload
   logic [OP_W-1:0]    op_ff;
   logic [IDX_W-1:0]   ri_ff, ci_ff, oi_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [CODE_W-1:0]  res_code_ff, res_code_in;
   logic               res_found_ff, res_found_in;
   logic [IDX_W-1:0]   res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // request fields
   logic [OP_W-1:0]    req_op;
   logic [IDX_W-1:0]   req_ri, req_ci, req_oi;
   logic               accept;

   // datapath nets
   logic [SIZE_W-1:0]  n;
   logic               item_in_range, last_pos, issue, hit;
   logic [AW-1:0]      item_addr, walk_addr;
   logic [RC_W-1:0]    src_r, src_c;
   logic [SIZE_W-1:0]  row_x, row_y, col_x, col_y, row_wrap, col_wrap;
   logic               row_ge, col_ge;
   logic               main_we, scr_we;
   logic [AW-1:0]      main_waddr, main_raddr, scr_raddr;
   logic [CODE_W-1:0]  main_wdata, main_q, main_rdata, scr_q;

   assign req_op = req_tdata[2:0];
   assign req_ri = req_tdata[5:3];
   assign req_ci = req_tdata[8:6];
   assign req_oi = req_tdata[11:9];
   assign accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // side in use: zero acts as one, clipped to the store size
   always_comb begin
      if (size_ff == '0) begin
         n = SIZE_W'(1);
      end else if (size_ff > SIDE_N) begin
         n = SIDE_N;
      end else begin
         n = size_ff;
      end
   end

   // position of the current item and of the walk
   assign item_in_range = (SIZE_W'(ri_ff) < n) && (SIZE_W'(ci_ff) < n);
   assign item_addr     = addr_of(RC_W'(ri_ff), RC_W'(ci_ff));
   assign walk_addr     = addr_of(r_ff, c_ff);
   assign last_pos      = (SIZE_W'(r_ff) == n - SIZE_W'(1)) &&
                          (SIZE_W'(c_ff) == n - SIZE_W'(1));

   // main store data, entries never written read as zero
   assign main_rdata = rd_valid_ff ? main_q : '0;
   assign hit        = (state_ff == S_FIND) && pend_vld_ff && (main_rdata == code_ff);
   assign issue      = walk_busy_ff && !hit &&
                       ((state_ff == S_FIND) || (state_ff == S_COPY) ||
                        (state_ff == S_PERM));

   // shared subtract units: shift reduction, then source row and column
   always_comb begin
      if (state_ff == S_MOD) begin
         row_x = a_ff;
         row_y = n;
         col_x = b_ff;
         col_y = n;
      end else begin
         row_x = SIZE_W'(r_ff);
         row_y = a_ff;
         col_x = SIZE_W'(c_ff);
         col_y = b_ff;
      end
   end

   ckss_wrap_sub u_row_sub (
      .x       (row_x),
      .y       (row_y),
      .n       (n),
      .ge      (row_ge),
      .wrapped (row_wrap)
   );

   ckss_wrap_sub u_col_sub (
      .x       (col_x),
      .y       (col_y),
      .n       (n),
      .ge      (col_ge),
      .wrapped (col_wrap)
   );

   // source position of the permutation
   always_comb begin
      src_r = r_ff;
      src_c = c_ff;
      case (op_ff)
         OP_SWAP_ROW: begin
            if (r_ff == RC_W'(ri_ff)) begin
               src_r = RC_W'(oi_ff);
            end else if (r_ff == RC_W'(oi_ff)) begin
               src_r = RC_W'(ri_ff);
            end
         end
         OP_SWAP_COL: begin
            if (c_ff == RC_W'(ci_ff)) begin
               src_c = RC_W'(oi_ff);
            end else if (c_ff == RC_W'(oi_ff)) begin
               src_c = RC_W'(ci_ff);
            end
         end
         OP_ROTATE: begin
            src_r = RC_W'(row_wrap);
            src_c = RC_W'(col_wrap);
         end
         default: begin
         end
      endcase
   end

   // memory ports
   assign main_we    = ((state_ff == S_WRITE) && item_in_range) ||
                       ((state_ff == S_PERM) && pend_vld_ff);
   assign main_waddr = (state_ff == S_WRITE) ? item_addr : pend_addr_ff;
   assign main_wdata = (state_ff == S_WRITE) ? code_ff : scr_q;
   assign main_raddr = (state_ff == S_READ) ? item_addr : walk_addr;
   assign scr_we     = (state_ff == S_COPY) && pend_vld_ff;
   assign scr_raddr  = addr_of(src_r, src_c);

   ckss_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_main_ram (
      .clock (clock),
      .we    (main_we),
      .waddr (main_waddr),
      .wdata (main_wdata),
      .raddr (main_raddr),
      .rdata (main_q)
   );

   ckss_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_scratch_ram (
      .clock (clock),
      .we    (scr_we),
      .waddr (pend_addr_ff),
      .wdata (main_rdata),
      .raddr (scr_raddr),
      .rdata (scr_q)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      walk_busy_in = walk_busy_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pend_vld_in  = issue;
      res_code_in  = res_code_ff;
      res_found_in = res_found_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // walk counter, row-major over the square
      if (issue) begin
         if (last_pos) begin
            walk_busy_in = 1'b0;
         end
         if (SIZE_W'(c_ff) == n - SIZE_W'(1)) begin
            c_in = '0;
            r_in = r_ff + RC_W'(1);
         end else begin
            c_in = c_ff + RC_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_code_in  = '0;
               res_found_in = 1'b0;
               res_row_in   = '0;
               res_col_in   = '0;
               r_in         = '0;
               c_in         = '0;
               a_in         = SIZE_W'(req_ri);
               b_in         = SIZE_W'(req_ci);
               case (req_op)
                  OP_WRITE: state_in = S_WRITE;
                  OP_READ:  state_in = S_READ;
                  OP_FIND: begin
                     walk_busy_in = 1'b1;
                     state_in     = S_FIND;
                  end
                  OP_SWAP_ROW: begin
                     if ((SIZE_W'(req_ri) < n) && (SIZE_W'(req_oi) < n)) begin
                        walk_busy_in = 1'b1;
                        state_in     = S_COPY;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_SWAP_COL: begin
                     if ((SIZE_W'(req_ci) < n) && (SIZE_W'(req_oi) < n)) begin
                        walk_busy_in = 1'b1;
                        state_in     = S_COPY;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_ROTATE: state_in = S_MOD;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_WRITE: state_in = S_DONE;
         S_READ: begin
            if (item_in_range) begin
               state_in = S_READ_WAIT;
            end else begin
               res_code_in = null_ff;
               state_in    = S_DONE;
            end
         end
         S_READ_WAIT: begin
            res_code_in = main_rdata;
            state_in    = S_DONE;
         end
         S_FIND: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_row_in   = IDX_W'(pend_r_ff);
               res_col_in   = IDX_W'(pend_c_ff);
               state_in     = S_DONE;
            end else if (!walk_busy_ff && !pend_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_MOD: begin
            // shifts taken modulo the side by repeated subtraction
            if (row_ge) begin
               a_in = row_wrap;
            end
            if (col_ge) begin
               b_in = col_wrap;
            end
            if (!row_ge && !col_ge) begin
               r_in         = '0;
               c_in         = '0;
               walk_busy_in = 1'b1;
               state_in     = S_COPY;
            end
         end
         S_COPY: begin
            if (!walk_busy_ff && !pend_vld_ff) begin
               r_in         = '0;
               c_in         = '0;
               walk_busy_in = 1'b1;
               state_in     = S_PERM;
            end
         end
         S_PERM: begin
            if (!walk_busy_ff && !pend_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_col_ff, res_row_ff, res_found_ff, res_code_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_busy_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
         null_ff      <= NULL_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            main_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         walk_busy_ff <= walk_busy_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (main_we) begin
            main_valid_ff[main_waddr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_MATRIX_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
               REG_NULL_CODE:   null_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      c_ff         <= c_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      pend_addr_ff <= walk_addr;
      pend_r_ff    <= r_ff;
      pend_c_ff    <= c_ff;
      rd_valid_ff  <= main_valid_ff[main_raddr];
      res_code_ff  <= res_code_in;
      res_found_ff <= res_found_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      rsp_data_ff  <= rsp_data_in;
      if (accept) begin
         op_ff   <= req_op;
         ri_ff   <= req_ri;
         ci_ff   <= req_ci;
         oi_ff   <= req_oi;
         code_ff <= req_tdata[19:12];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ckss_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ckss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/ckss_wrap_sub.sv
// shared subtract and wrap unit: (x - y) mod n for x, y below n,
// and the plain difference with a flag for x >= y; uses ckss_pkg
`default_nettype none

module ckss_wrap_sub import ckss_pkg::*; (
   input  wire logic [SIZE_W-1:0] x,
   input  wire logic [SIZE_W-1:0] y,
   input  wire logic [SIZE_W-1:0] n,
   output logic                   ge,
   output logic      [SIZE_W-1:0] wrapped
);

   logic [SIZE_W:0] diff;

   // one subtract, one conditional add of n
   always_comb begin
      diff    = {1'b0, x} - {1'b0, y};
      ge      = ~diff[SIZE_W];
      wrapped = ge ? diff[SIZE_W-1:0] : diff[SIZE_W-1:0] + n;
   end

endmodule

`default_nettype wire

>>> hw/rtl/ckss_checker.sv
// port-level checks of the key square store, bound to the top level
// depends on ckss_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ckss_checker import ckss_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_W-1:0]      rsp_tdata
);

   // a stalled result item holds
   `ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")

   // the block is busy right after it takes an item
   `ASSERT_SYNC(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "item taken in back to back cycles")

   // position fields are zero unless a code was found
   `ASSERT_SYNC(a_pos_zero, clock, reset, rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[14:9] == 6'd0, "position set without a find hit")

   // a find hit carries no read code
   `ASSERT_SYNC(a_hit_no_code, clock, reset, rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0, "find hit with nonzero read code")

   // reset leaves the block empty and ready
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind cipher_key_square_store_core ckss_checker u_ckss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking bench for the key square store: ops go in on the req stream,
// answers are checked on the rsp stream against an in-bench square predictor
// depends on ckss_pkg and cipher_key_square_store_core
`timescale 1ns / 1ps

module tb_top;
   import ckss_pkg::*;

   localparam int KEY_SIDE = MAX_SIDE_DEFAULT;
   localparam int PHASES   = 8;

   // spare op codes that the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // request item, op in the lowest bits
   typedef struct packed {
      logic [3:0]        pad;
      logic [CODE_W-1:0] code;
      logic [IDX_W-1:0]  other;
      logic [IDX_W-1:0]  col;
      logic [IDX_W-1:0]  row;
      logic [OP_W-1:0]   op;
   } square_cmd_type;

   // answer item, read_code in the lowest bits
   typedef struct packed {
      logic              pad;
      logic [IDX_W-1:0]  found_col;
      logic [IDX_W-1:0]  found_row;
      logic              found;
      logic [CODE_W-1:0] read_code;
   } square_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [CODE_W-1:0] square_store [0:KEY_SIDE*KEY_SIDE-1];
   logic [SIZE_W-1:0] side_reg = SIZE_RESET;
   logic [CODE_W-1:0] null_reg = NULL_RESET;

   square_cmd_type    pending_cmds [$];
   square_answer_type expected_answers [$];
   logic [CODE_W-1:0] recent_codes [0:7];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned answers_seen = 0;
   int unsigned mismatch_count = 0;

   int phase_size [PHASES] = '{8, 1, 0, 15, 3, 8, 6, 2};
   int phase_null [PHASES] = '{255, 128, 37, 0, 90, 0, 255, 201};
   int phase_items [PHASES] = '{280, 160, 160, 280, 240, 290, 260, 255};

   cipher_key_square_store_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // side length in use, clamped to 1..KEY_SIDE
   function automatic int unsigned used_side(logic [SIZE_W-1:0] size);
      int unsigned n;
      n = size;
      if (n == 0) n = 1;
      if (n > KEY_SIDE) n = KEY_SIDE;
      return n;
   endfunction

   // apply one op to the predicted square and return its answer
   function automatic square_answer_type predict_square_op(square_cmd_type cmd);
      square_answer_type ans;
      logic [CODE_W-1:0] snap [0:KEY_SIDE*KEY_SIDE-1];
      logic [CODE_W-1:0] held;
      int unsigned       n, a, b, r, c, ri, ci, oi;
      logic              hit;
      ans = '0;
      hit = 1'b0;
      n   = used_side(side_reg);
      ri  = cmd.row;
      ci  = cmd.col;
      oi  = cmd.other;
      case (cmd.op)
         OP_WRITE: begin
            if (ri < n && ci < n) square_store[ri*KEY_SIDE+ci] = cmd.code;
         end
         OP_READ: begin
            ans.read_code = (ri < n && ci < n) ? square_store[ri*KEY_SIDE+ci] : null_reg;
         end
         OP_FIND: begin
            // first match in row-major order
            for (r = 0; r < n; r++)
               for (c = 0; c < n; c++)
                  if (!hit && square_store[r*KEY_SIDE+c] == cmd.code) begin
                     hit = 1'b1;
                     ans.found = 1'b1;
                     ans.found_row = r[IDX_W-1:0];
                     ans.found_col = c[IDX_W-1:0];
                  end
         end
         OP_SWAP_ROW: begin
            if (ri < n && oi < n)
               for (c = 0; c < n; c++) begin
                  held = square_store[ri*KEY_SIDE+c];
                  square_store[ri*KEY_SIDE+c] = square_store[oi*KEY_SIDE+c];
                  square_store[oi*KEY_SIDE+c] = held;
               end
         end
         OP_SWAP_COL: begin
            if (ci < n && oi < n)
               for (r = 0; r < n; r++) begin
                  held = square_store[r*KEY_SIDE+ci];
                  square_store[r*KEY_SIDE+ci] = square_store[r*KEY_SIDE+oi];
                  square_store[r*KEY_SIDE+oi] = held;
               end
         end
         OP_ROTATE: begin
            // new (r,c) takes old ((r-a) mod n, (c-b) mod n)
            a = ri % n;
            b = ci % n;
            snap = square_store;
            for (r = 0; r < n; r++)
               for (c = 0; c < n; c++)
                  square_store[r*KEY_SIDE+c] =
                     snap[((r + n - a) % n)*KEY_SIDE + (c + n - b) % n];
         end
         default: ;
      endcase
      return ans;
   endfunction

   // index mostly inside the square, sometimes anywhere
   function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
      if ($urandom_range(9) < 8) return IDX_W'($urandom_range(n - 1));
      return IDX_W'($urandom_range(7));
   endfunction

   // random op, weighted toward well-formed traffic on the square in use
   function automatic square_cmd_type random_cmd(int unsigned n);
      square_cmd_type cmd;
      int unsigned pick;
      pick = $urandom_range(99);
      cmd = '0;
      cmd.row = pick_index(n);
      cmd.col = pick_index(n);
      cmd.other = pick_index(n);
      cmd.code = CODE_W'($urandom_range(255));
      if (pick < 30) begin
         cmd.op = OP_WRITE;
         recent_codes[$urandom_range(7)] = cmd.code;
      end else if (pick < 52) begin
         cmd.op = OP_READ;
      end else if (pick < 70) begin
         cmd.op = OP_FIND;
         if ($urandom_range(9) < 6) cmd.code = recent_codes[$urandom_range(7)];
      end else if (pick < 78) begin
         cmd.op = OP_SWAP_ROW;
      end else if (pick < 86) begin
         cmd.op = OP_SWAP_COL;
      end else if (pick < 95) begin
         cmd.op = OP_ROTATE;
         cmd.row = IDX_W'($urandom_range(7));
         cmd.col = IDX_W'($urandom_range(7));
      end else begin
         // noise: any bit pattern, spare ops included
         cmd = square_cmd_type'(REQ_W'($urandom));
         cmd.pad = '0;
      end
      return cmd;
   endfunction

   task automatic queue_cmd(input logic [OP_W-1:0] op, input int row, input int col,
                            input int other, input int code);
      square_cmd_type cmd;
      cmd = '0;
      cmd.op = op;
      cmd.row = IDX_W'(row);
      cmd.col = IDX_W'(col);
      cmd.other = IDX_W'(other);
      cmd.code = CODE_W'(code);
      pending_cmds.push_back(cmd);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
         default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   task automatic wait_drained();
      while (!(pending_cmds.size() == 0 && !req_tvalid && expected_answers.size() == 0))
         @(posedge clock);
   endtask

   // request driver: holds an item until accepted, predicts it on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_answers.push_back(predict_square_op(square_cmd_type'(req_tdata)));
            items_sent++;
         end
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= pending_cmds.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // answer monitor: checks each accepted item against the oldest prediction
   always @(posedge clock) begin
      square_answer_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = square_answer_type'(rsp_tdata);
            answers_seen++;
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: answer with none pending: %h", $realtime, rsp_tdata);
            end else begin
               want = expected_answers.pop_front();
               if (got.read_code !== want.read_code || got.found !== want.found ||
                   got.found_row !== want.found_row || got.found_col !== want.found_col ||
                   got.pad !== 1'b0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: answer mismatch: expected code %h found %b at ",
                               "(%0d,%0d), got code %h found %b at (%0d,%0d)"},
                              $realtime, want.read_code, want.found, want.found_row,
                              want.found_col, got.read_code, got.found, got.found_row,
                              got.found_col);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // stimulus sequence
   initial begin
      int p, k;
      int unsigned n;
      for (k = 0; k < KEY_SIDE*KEY_SIDE; k++) square_store[k] = NULL_RESET;
      for (k = 0; k < 8; k++) recent_codes[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed ops at the reset setting (side 5, null 0)
      set_idling(0);
      queue_cmd(OP_READ,      0, 0, 0, 0);
      queue_cmd(OP_WRITE,     0, 0, 0, 255);
      queue_cmd(OP_WRITE,     4, 4, 0, 165);
      queue_cmd(OP_WRITE,     0, 4, 0, 90);
      queue_cmd(OP_WRITE,     4, 0, 0, 60);
      queue_cmd(OP_WRITE,     7, 7, 7, 17);
      queue_cmd(OP_READ,      4, 4, 0, 0);
      queue_cmd(OP_READ,      5, 0, 0, 0);
      queue_cmd(OP_READ,      0, 7, 0, 0);
      queue_cmd(OP_FIND,      0, 0, 0, 255);
      queue_cmd(OP_FIND,      0, 0, 0, 0);
      queue_cmd(OP_FIND,      0, 0, 0, 17);
      queue_cmd(OP_SWAP_ROW,  0, 0, 4, 0);
      queue_cmd(OP_SWAP_ROW,  1, 0, 6, 0);
      queue_cmd(OP_SWAP_COL,  0, 0, 4, 0);
      queue_cmd(OP_SWAP_COL,  0, 2, 2, 0);
      queue_cmd(OP_SWAP_COL,  0, 7, 0, 0);
      queue_cmd(OP_ROTATE,    1, 2, 0, 0);
      queue_cmd(OP_ROTATE,    7, 7, 0, 0);
      queue_cmd(OP_ROTATE,    0, 0, 0, 0);
      queue_cmd(OP_SPARE_LO,  7, 7, 7, 255);
      queue_cmd(OP_SPARE_HI,  7, 7, 7, 255);
      queue_cmd(OP_READ,      0, 0, 0, 0);
      queue_cmd(OP_FIND,      0, 0, 0, 165);
      wait_drained();

      // random phases over several settings, sizes out of range among them
      for (p = 0; p < PHASES; p++) begin
         write_reg(REG_MATRIX_SIZE, phase_size[p]);
         write_reg(REG_NULL_CODE, phase_null[p]);
         side_reg = SIZE_W'(phase_size[p]);
         null_reg = CODE_W'(phase_null[p]);
         set_idling(p % 4);
         n = used_side(side_reg);
         for (k = 0; k < phase_items[p]; k++) pending_cmds.push_back(random_cmd(n));
         wait_drained();
      end

      // let any stray answer show up
      repeat (300) @(posedge clock);
      mismatch_count += expected_answers.size();
      $display("covered %0d items and %0d answers over %0d settings",
               items_sent, answers_seen, PHASES + 1);
      $display("sides 0 to 15 and null codes 0 to 255, idling none, sender, receiver, both");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("timeout with %0d answers still pending", expected_answers.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
